// ===== hw/rtl/aext_pkg.sv =====
// ----------------------------------------------------------------------------
// aext_pkg
// Shared types, codes and sizing constants for the advertising record
// extractor: parse phases, record and status codes, and the result word.
// ----------------------------------------------------------------------------
package aext_pkg;

	// Report and entry geometry
	localparam int MAX_REPORT_BYTES = 1650;
	localparam int ENTRY_STRIDE     = 7;
	localparam int POS_W            = $clog2(MAX_REPORT_BYTES + 1);
	localparam int OFF_W            = $clog2(ENTRY_STRIDE);
	// ID bytes an entry carries, and the zero fill below them
	localparam int ENTRY_GOT        = (ENTRY_STRIDE - 1 < 5) ? (ENTRY_STRIDE - 1) : 5;
	localparam int ENTRY_PAD_BITS   = 8 * (5 - ENTRY_GOT);
	localparam int BEACON_ID_BYTES  = 16;

	// Result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Configuration register indexes
	localparam logic [1:0] REG_ID_PREFIX    = 2'd0;
	localparam logic [1:0] REG_SERVICE_UUID = 2'd1;
	localparam logic [1:0] REG_SERVICE_TYPE = 2'd2;
	localparam logic [1:0] REG_MAKER_TYPE   = 2'd3;

	// Configuration reset values
	localparam logic [23:0] ID_PREFIX_RST    = 24'h393530;
	localparam logic [15:0] SERVICE_UUID_RST = 16'h2AF5;
	localparam logic [7:0]  SERVICE_TYPE_RST = 8'h2A;
	localparam logic [7:0]  MAKER_TYPE_RST   = 8'hFF;

	// Record kinds
	localparam logic [1:0] KIND_BEACON     = 2'd0;
	localparam logic [1:0] KIND_EXTENDER   = 2'd1;
	localparam logic [1:0] KIND_CALIBRATOR = 2'd2;
	localparam logic [1:0] KIND_STATUS     = 2'd3;

	// Parse status codes
	localparam logic [1:0] STAT_BEACON  = 2'd0;
	localparam logic [1:0] STAT_ENTRIES = 2'd1;
	localparam logic [1:0] STAT_ERROR   = 2'd2;

	// Entry modes
	localparam logic [7:0] MODE_EXTENDER   = 8'd0;
	localparam logic [7:0] MODE_CALIBRATOR = 8'd1;

	typedef enum logic [2:0] {
		PH_LEN,
		PH_TYPE,
		PH_HDR0,
		PH_HDR1,
		PH_SKIP,
		PH_BEACON,
		PH_ENTRY
	} phase_t;

	typedef struct packed {
		logic svc;
		logic mfr;
		logic body;
	} hdr_flags_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [47:0]       school;
		logic [63:0]       head;
		logic [15:0]       tail;
		logic signed [7:0] level;
		logic [1:0]        status;
		logic              last;
	} result_t;

	// Up to two results per accepted byte, slot 0 first
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic result_t status_result(input logic [1:0] status);
		result_t r;
		r        = '0;
		r.kind   = KIND_STATUS;
		r.status = status;
		r.last   = 1'b1;
		return r;
	endfunction

endpackage

// ===== hw/rtl/aext_parser.sv =====
// ----------------------------------------------------------------------------
// aext_parser
// Holds the configuration and the parse state, and walks one payload byte
// per accepted word, producing zero, one or two results for that byte.
// ----------------------------------------------------------------------------
module aext_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [23:0]           cfg_wdata,
	input  logic                  accept,
	input  logic [7:0]            payload_byte,
	input  logic                  first_byte,
	input  logic                  last_byte,
	input  logic signed [7:0]     report_rssi,
	output aext_pkg::push_t       push
);

	logic [23:0] id_prefix_q;
	logic [15:0] service_uuid_q;
	logic [7:0]  service_type_q;
	logic [7:0]  maker_type_q;

	logic [aext_pkg::POS_W-1:0] pos_q, pos_d;
	logic [7:0]                 sleft_q, sleft_d;
	aext_pkg::phase_t           phase_q, phase_d;
	logic [63:0]                shift0_q, shift0_d;
	logic [63:0]                shift1_q, shift1_d;
	logic [7:0]                 mode_q, mode_d;
	logic [7:0]                 eleft_q, eleft_d;
	logic [aext_pkg::OFF_W-1:0] eoff_q, eoff_d;
	logic [7:0]                 elevel_q, elevel_d;
	logic                       done_q, done_d;
	aext_pkg::hdr_flags_t       flags_q, flags_d;

	aext_pkg::push_t push_c;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_prefix_q    <= aext_pkg::ID_PREFIX_RST;
			service_uuid_q <= aext_pkg::SERVICE_UUID_RST;
			service_type_q <= aext_pkg::SERVICE_TYPE_RST;
			maker_type_q   <= aext_pkg::MAKER_TYPE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				aext_pkg::REG_ID_PREFIX:    id_prefix_q    <= cfg_wdata;
				aext_pkg::REG_SERVICE_UUID: service_uuid_q <= cfg_wdata[15:0];
				aext_pkg::REG_SERVICE_TYPE: service_type_q <= cfg_wdata[7:0];
				aext_pkg::REG_MAKER_TYPE:   maker_type_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Next parse state and results for the incoming byte
	always_comb begin
		aext_pkg::result_t res;
		aext_pkg::phase_t  ph;
		logic [7:0]        cnt_n;
		logic [7:0]        left_n;
		logic [39:0]       id_bits;

		res     = '0;
		ph      = aext_pkg::PH_LEN;
		cnt_n   = '0;
		left_n  = '0;
		id_bits = '0;
		push_c  = '0;

		// a first byte restarts the report
		if (first_byte) begin
			pos_d    = '0;
			sleft_d  = '0;
			phase_d  = aext_pkg::PH_LEN;
			shift0_d = '0;
			shift1_d = '0;
			mode_d   = '0;
			eleft_d  = '0;
			eoff_d   = '0;
			elevel_d = '0;
			done_d   = 1'b0;
			flags_d  = '0;
		end else begin
			pos_d    = pos_q;
			sleft_d  = sleft_q;
			phase_d  = phase_q;
			shift0_d = shift0_q;
			shift1_d = shift1_q;
			mode_d   = mode_q;
			eleft_d  = eleft_q;
			eoff_d   = eoff_q;
			elevel_d = elevel_q;
			done_d   = done_q;
			flags_d  = flags_q;
		end

		if (!done_d) begin
			if (pos_d >= aext_pkg::POS_W'(aext_pkg::MAX_REPORT_BYTES)) begin
				// report too long
				push_c.r0    = aext_pkg::status_result(aext_pkg::STAT_ERROR);
				push_c.count = 2'd1;
				done_d       = 1'b1;
			end else begin
				pos_d = pos_d + 1'b1;

				// leave a finished non-manufacturer structure
				ph = phase_d;
				if ((ph == aext_pkg::PH_HDR0 || ph == aext_pkg::PH_HDR1 ||
				     ph == aext_pkg::PH_SKIP) && !flags_d.mfr && sleft_d == 8'd0)
					ph = aext_pkg::PH_LEN;
				phase_d = ph;

				case (ph)
					aext_pkg::PH_LEN: begin
						if (payload_byte == 8'd0) begin
							push_c.r0    = aext_pkg::status_result(aext_pkg::STAT_ERROR);
							push_c.count = 2'd1;
							done_d       = 1'b1;
						end else begin
							sleft_d = payload_byte;
							phase_d = aext_pkg::PH_TYPE;
						end
					end
					aext_pkg::PH_TYPE: begin
						if (sleft_d != 8'd0) sleft_d = sleft_d - 1'b1;
						flags_d.svc  = (payload_byte == service_type_q);
						flags_d.mfr  = (payload_byte == maker_type_q);
						flags_d.body = 1'b0;
						phase_d = (flags_d.svc || flags_d.mfr) ? aext_pkg::PH_HDR0
						                                      : aext_pkg::PH_SKIP;
					end
					aext_pkg::PH_HDR0: begin
						if (sleft_d >= 8'd2) flags_d.body = 1'b1;
						if (sleft_d != 8'd0) sleft_d = sleft_d - 1'b1;
						mode_d  = payload_byte;
						phase_d = aext_pkg::PH_HDR1;
					end
					aext_pkg::PH_HDR1: begin
						if (sleft_d != 8'd0) sleft_d = sleft_d - 1'b1;
						if (flags_d.svc && flags_d.body &&
						    mode_d == service_uuid_q[7:0] &&
						    payload_byte == service_uuid_q[15:8]) begin
							phase_d  = aext_pkg::PH_BEACON;
							eleft_d  = '0;
							shift0_d = '0;
							shift1_d = '0;
						end else if (flags_d.mfr) begin
							eleft_d = payload_byte;
							eoff_d  = '0;
							if (payload_byte == 8'd0) begin
								push_c.r0    = aext_pkg::status_result(aext_pkg::STAT_ENTRIES);
								push_c.count = 2'd1;
								done_d       = 1'b1;
							end else begin
								phase_d = aext_pkg::PH_ENTRY;
							end
						end else begin
							phase_d = aext_pkg::PH_SKIP;
						end
					end
					aext_pkg::PH_SKIP: begin
						if (sleft_d != 8'd0) sleft_d = sleft_d - 1'b1;
					end
					aext_pkg::PH_BEACON: begin
						// school bytes and last two student bytes go to shift0
						if (eleft_d < 8'd6 || eleft_d >= 8'd14)
							shift0_d = {shift0_d[55:0], payload_byte};
						else
							shift1_d = {shift1_d[55:0], payload_byte};
						cnt_n   = eleft_d + 1'b1;
						eleft_d = cnt_n;
						if (cnt_n >= 8'(aext_pkg::BEACON_ID_BYTES)) begin
							res.kind     = aext_pkg::KIND_BEACON;
							res.school   = shift0_d[63:16];
							res.head     = shift1_d;
							res.tail     = shift0_d[15:0];
							res.level    = report_rssi;
							res.status   = aext_pkg::STAT_BEACON;
							res.last     = 1'b0;
							push_c.r0    = res;
							push_c.r1    = aext_pkg::status_result(aext_pkg::STAT_BEACON);
							push_c.count = 2'd2;
							done_d       = 1'b1;
						end
					end
					aext_pkg::PH_ENTRY: begin
						if (eoff_d == '0) begin
							elevel_d = payload_byte;
							shift1_d = '0;
						end else if (8'(eoff_d) <= 8'd5) begin
							shift1_d = {shift1_d[55:0], payload_byte};
						end
						if (eoff_d >= aext_pkg::OFF_W'(aext_pkg::ENTRY_STRIDE - 1)) begin
							id_bits    = shift1_d[39:0] << aext_pkg::ENTRY_PAD_BITS;
							res.school = '0;
							res.head   = {id_prefix_q, id_bits};
							res.tail   = '0;
							res.level  = elevel_d;
							res.status = '0;
							res.last   = 1'b0;
							if (mode_d == aext_pkg::MODE_EXTENDER) begin
								res.kind     = aext_pkg::KIND_EXTENDER;
								push_c.r0    = res;
								push_c.count = 2'd1;
							end else if (mode_d == aext_pkg::MODE_CALIBRATOR) begin
								res.kind     = aext_pkg::KIND_CALIBRATOR;
								push_c.r0    = res;
								push_c.count = 2'd1;
							end
							eoff_d = '0;
							left_n = (eleft_d != 8'd0) ? (eleft_d - 1'b1) : eleft_d;
							eleft_d = left_n;
							if (left_n == 8'd0) begin
								if (push_c.count == 2'd0)
									push_c.r0 = aext_pkg::status_result(aext_pkg::STAT_ENTRIES);
								else
									push_c.r1 = aext_pkg::status_result(aext_pkg::STAT_ENTRIES);
								push_c.count = push_c.count + 1'b1;
								done_d       = 1'b1;
							end
						end else begin
							eoff_d = eoff_d + 1'b1;
						end
					end
					default: begin
						phase_d = aext_pkg::PH_LEN;
					end
				endcase

				// report ended before any finishing structure
				if (last_byte && !done_d) begin
					if (push_c.count == 2'd0)
						push_c.r0 = aext_pkg::status_result(aext_pkg::STAT_ERROR);
					else
						push_c.r1 = aext_pkg::status_result(aext_pkg::STAT_ERROR);
					push_c.count = push_c.count + 1'b1;
					done_d       = 1'b1;
				end
			end
		end
	end

	// Advance parse state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sleft_q  <= '0;
			phase_q  <= aext_pkg::PH_LEN;
			shift0_q <= '0;
			shift1_q <= '0;
			mode_q   <= '0;
			eleft_q  <= '0;
			eoff_q   <= '0;
			elevel_q <= '0;
			done_q   <= 1'b0;
			flags_q  <= '0;
		end else if (accept) begin
			pos_q    <= pos_d;
			sleft_q  <= sleft_d;
			phase_q  <= phase_d;
			shift0_q <= shift0_d;
			shift1_q <= shift1_d;
			mode_q   <= mode_d;
			eleft_q  <= eleft_d;
			eoff_q   <= eoff_d;
			elevel_q <= elevel_d;
			done_q   <= done_d;
			flags_q  <= flags_d;
		end
	end

	// Only push on an accepted word
	always_comb begin
		push = push_c;
		if (!accept) push.count = 2'd0;
	end

endmodule

// ===== hw/rtl/aext_fifo.sv =====
// ----------------------------------------------------------------------------
// aext_fifo
// Small result queue: takes up to two results per cycle, hands out one per
// cycle, and reports room for two more.
// ----------------------------------------------------------------------------
module aext_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  aext_pkg::push_t   push,
	input  logic              pop,
	output aext_pkg::result_t head,
	output logic              not_empty,
	output logic              room
);

	aext_pkg::result_t mem_q [aext_pkg::FIFO_DEPTH];

	logic [aext_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [aext_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [aext_pkg::FIFO_AW:0]   count_q;
	logic [aext_pkg::FIFO_AW-1:0] wr_next;
	logic                         do_pop;

	assign wr_next   = wr_ptr_q + 1'b1;
	assign not_empty = (count_q != '0);
	assign do_pop    = pop && not_empty;
	assign room      = (count_q <= (aext_pkg::FIFO_AW + 1)'(aext_pkg::FIFO_DEPTH - 2));
	assign head      = mem_q[rd_ptr_q];

	// Store incoming results
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem_q[wr_ptr_q] <= push.r0;
		if (push.count == 2'd2) mem_q[wr_next]  <= push.r1;
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + aext_pkg::FIFO_AW'(push.count);
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (aext_pkg::FIFO_AW + 1)'(push.count)
			         - (aext_pkg::FIFO_AW + 1)'(do_pop);
		end
	end

endmodule

// ===== hw/rtl/adv_record_extractor.sv =====
// ----------------------------------------------------------------------------
// adv_record_extractor
// Walks advertising payload bytes, one per word, and emits beacon records,
// prefixed manufacturer entry records and one closing status per report.
//
//  channel  | direction | content
//  ---------+-----------+--------------------------------------------------
//  s_*      | in        | payload byte, report RSSI, first byte, last byte
//  m_*      | out       | record fields, record kind, run end
//  cfg_*    | in        | register writes, no read-back
//
// One byte is accepted per cycle whenever the result queue has room for two
// more results; a result is queued and shows on m_tvalid once at the head. Results
// drain at one per cycle, so m_tready low for long lets results pile up in the
// four-entry queue, and s_tready drops once fewer than two entries are free.
// Reset clears parse state, the queue and the registers to their defaults.
// ----------------------------------------------------------------------------
module adv_record_extractor (
	input  logic          clk,
	input  logic          arst_n,
	// configuration
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [23:0]   cfg_wdata,
	// payload in
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [15:0]   s_tdata,   // payload_byte[7:0], report_rssi[15:8]
	input  logic          s_tuser,   // first_byte
	input  logic          s_tlast,   // last_byte
	// records out
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [143:0]  m_tdata,   // school_code[47:0], student_head[111:48],
	                                 // student_tail[127:112], signal_level[135:128],
	                                 // parse_status[137:136], zero[143:138]
	output logic [1:0]    m_tuser,   // record_kind
	output logic          m_tlast    // run_last
);

	aext_pkg::push_t   push;
	aext_pkg::result_t head;
	logic              accept;
	logic              room;
	logic              not_empty;

	// Take a word only when two results fit
	assign s_tready = room;
	assign accept   = s_tvalid && room;

	aext_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.accept       (accept),
		.payload_byte (s_tdata[7:0]),
		.first_byte   (s_tuser),
		.last_byte    (s_tlast),
		.report_rssi  (s_tdata[15:8]),
		.push         (push)
	);

	aext_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (m_tready),
		.head      (head),
		.not_empty (not_empty),
		.room      (room)
	);

	// Pack the head result onto the output word
	assign m_tvalid = not_empty;
	assign m_tdata  = {6'd0, head.status, head.level, head.tail, head.head, head.school};
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;

endmodule
